// ===== design/erfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Error function unit package
// Shared widths, Q30 coefficients and stage sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package erfa_pkg;

	localparam int X_W           = 16;
	localparam int R_W           = 16;
	localparam int IN_FRAC_BITS  = 12;
	localparam int OUT_FRAC_BITS = 14;

	localparam int     QF    = 30;
	localparam longint QONE  = longint'(1) << QF;
	localparam longint QHALF = longint'(1) << (QF - 1);

	localparam longint COEF_A1 =
		(longint'(254829592) * QONE + longint'(500000000)) / longint'(1000000000);
	localparam longint COEF_A2 =
		-((longint'(284496736) * QONE + longint'(500000000)) / longint'(1000000000));
	localparam longint COEF_A3 =
		(longint'(1421413741) * QONE + longint'(500000000)) / longint'(1000000000);
	localparam longint COEF_A4 =
		-((longint'(1453152027) * QONE + longint'(500000000)) / longint'(1000000000));
	localparam longint COEF_A5 =
		(longint'(1061405429) * QONE + longint'(500000000)) / longint'(1000000000);
	localparam longint COEF_P =
		(longint'(3275911) * QONE + longint'(5000000)) / longint'(10000000);

	localparam int A_W  = X_W;
	localparam int P_W  = $clog2(COEF_P + 1);
	localparam int PA_W = P_W + A_W;
	localparam longint D_MAX = QONE +
		(((COEF_P << (X_W - 1)) + (longint'(1) << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS);
	localparam int D_W  = $clog2(D_MAX + 1);
	localparam int T_W  = QF + 1;

	localparam int SQ_W = 2 * A_W;
	localparam int SSH  = QF - 2 * IN_FRAC_BITS;
	localparam int SSHL = (SSH > 0) ? SSH : 0;
	localparam int SSHR = (SSH < 0) ? -SSH : 0;
	localparam longint SSHR_RND = (SSHR == 0) ? 0 : (longint'(1) << (SSHR - 1));
	localparam int S_W  = SQ_W + SSHL + 1;

	localparam longint EXP_LIM = longint'(22) << QF;
	localparam int     YSH     = 6;
	localparam longint Y_RND   = longint'(1) << (YSH - 1);
	localparam int     Y_W     = $clog2((EXP_LIM >> YSH) + 1);

	localparam int TM_W    = QF + 1;
	localparam int SUM_W   = QF + 2;
	localparam int MK_W    = QF + 2;
	localparam int Q_W     = QF + 3;
	localparam int QM_W    = QF + 2;
	localparam int ER_W    = Q_W + 1;
	localparam int N_TERMS = 12;
	localparam int N_SQ    = 6;
	localparam int N_HORN  = 5;

	localparam int     OSH   = QF - OUT_FRAC_BITS;
	localparam longint O_RND = (OSH == 0) ? 0 : (longint'(1) << (OSH - 1));

	typedef struct packed {
		logic           neg;
		logic           mode;
		logic           ez;
		logic [Y_W-1:0] y;
	} side_t;

	function automatic logic signed [Q_W-1:0] horner_coef(input int step);
		logic signed [Q_W-1:0] c;
		unique case (step)
			0:       c = Q_W'(COEF_A4);
			1:       c = Q_W'(COEF_A3);
			2:       c = Q_W'(COEF_A2);
			3:       c = Q_W'(COEF_A1);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/erfa_div.sv =====
// ----------------------------------------------------------------------------
// Reciprocal divider
// Pipelined restoring division, one quotient bit per stage: t = 2^60 / d.
// ----------------------------------------------------------------------------
`default_nettype none

module erfa_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [erfa_pkg::D_W-1:0] den,
	input  wire erfa_pkg::side_t        in_side,
	output logic                        out_valid,
	output logic [erfa_pkg::T_W-1:0]    quot,
	output erfa_pkg::side_t             out_side
);
	import erfa_pkg::*;

	localparam int NST = T_W;
	localparam int NM_W = D_W + T_W;

	typedef struct packed {
		logic [D_W-1:0] rem;
		logic [T_W-1:0] nlo;
		logic [T_W-1:0] quo;
		logic [D_W-1:0] den;
		side_t          side;
	} div_stg_t;

	div_stg_t          head;
	div_stg_t          stg_s [NST];
	logic              vld_s [NST];
	logic [NM_W-1:0]   numer;

	// numerator 2^60 + d/2 gives the rounded quotient
	assign numer = NM_W'(longint'(1) << (2 * QF)) + NM_W'(den[D_W-1:1]);

	always_comb begin
		head.rem  = numer[NM_W-1:T_W];
		head.nlo  = numer[T_W-1:0];
		head.quo  = '0;
		head.den  = den;
		head.side = in_side;
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		div_stg_t src;
		div_stg_t nxt;
		logic     src_v;

		if (i == 0) begin : g_first
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stg_s[i-1];
			assign src_v = vld_s[i-1];
		end

		always_comb begin
			logic [D_W:0] wide;
			nxt  = src;
			wide = {src.rem, src.nlo[T_W-1]};
			nxt.nlo = {src.nlo[T_W-2:0], 1'b0};
			if (wide >= {1'b0, src.den}) begin
				nxt.rem = D_W'(wide - {1'b0, src.den});
				nxt.quo = {src.quo[T_W-2:0], 1'b1};
			end else begin
				nxt.rem = wide[D_W-1:0];
				nxt.quo = {src.quo[T_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign quot      = stg_s[NST-1].quo;
	assign out_side  = stg_s[NST-1].side;

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] |-> stg_s[NST-1].quo <= T_W'(QONE))
		else $error("reciprocal above one");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] |-> stg_s[NST-1].rem < stg_s[NST-1].den)
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ===== design/erfa_horner.sv =====
// ----------------------------------------------------------------------------
// Polynomial evaluator
// Degree-five Horner chain in t, a multiply stage and a round/add stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module erfa_horner (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [erfa_pkg::T_W-1:0]    t,
	input  wire erfa_pkg::side_t             in_side,
	output logic                             out_valid,
	output logic signed [erfa_pkg::Q_W-1:0]  poly,
	output erfa_pkg::side_t                  out_side
);
	import erfa_pkg::*;

	localparam int NST = 2 * N_HORN;
	localparam int PR_W = QM_W + T_W;

	typedef struct packed {
		logic [PR_W-1:0]       prod;
		logic                  pneg;
		logic signed [Q_W-1:0] q;
		logic [T_W-1:0]        t;
		side_t                 side;
	} hstg_t;

	hstg_t head;
	hstg_t stg_s [NST];
	logic  vld_s [NST];

	always_comb begin
		head.prod = '0;
		head.pneg = 1'b0;
		head.q    = Q_W'(COEF_A5);
		head.t    = t;
		head.side = in_side;
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		localparam int J   = i / 2;
		localparam int SUB = i % 2;

		hstg_t src;
		hstg_t nxt;
		logic  src_v;

		if (i == 0) begin : g_first
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stg_s[i-1];
			assign src_v = vld_s[i-1];
		end

		if (SUB == 0) begin : g_mul
			always_comb begin
				logic [Q_W-1:0] qabs;
				nxt      = src;
				qabs     = src.q[Q_W-1] ? Q_W'(-src.q) : Q_W'(src.q);
				nxt.prod = qabs[QM_W-1:0] * src.t;
				nxt.pneg = src.q[Q_W-1];
			end
		end else begin : g_add
			always_comb begin
				logic [PR_W-1:0]       rw;
				logic signed [Q_W-1:0] m;
				nxt   = src;
				rw    = src.prod + PR_W'(QHALF);
				m     = Q_W'(rw[QF +: QM_W]);
				nxt.q = (src.pneg ? -m : m) + horner_coef(J);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign poly      = stg_s[NST-1].q;
	assign out_side  = stg_s[NST-1].side;

endmodule

`default_nettype wire

// ===== design/erfa_exp.sv =====
// ----------------------------------------------------------------------------
// Negative exponential
// exp(-s) as a series in y = s/64 up to the twelfth power, then squared six times.
// ----------------------------------------------------------------------------
`default_nettype none

module erfa_exp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic signed [erfa_pkg::Q_W-1:0] in_poly,
	input  wire erfa_pkg::side_t             in_side,
	output logic                             out_valid,
	output logic [erfa_pkg::SUM_W-1:0]       expo,
	output logic signed [erfa_pkg::Q_W-1:0]  out_poly,
	output erfa_pkg::side_t                  out_side
);
	import erfa_pkg::*;

	localparam int NT  = 4 * N_TERMS;
	localparam int NST = NT + 2 * N_SQ;
	localparam int WD_W = 2 * SUM_W;
	localparam int RM_W = TM_W + 4;

	typedef struct packed {
		logic [TM_W-1:0]       term;
		logic [SUM_W-1:0]      sum;
		logic [WD_W-1:0]       wide;
		logic [TM_W-1:0]       n;
		logic signed [Q_W-1:0] q;
		side_t                 side;
	} estg_t;

	estg_t head;
	estg_t stg_s [NST];
	logic  vld_s [NST];

	always_comb begin
		head.term = TM_W'(QONE);
		head.sum  = SUM_W'(QONE);
		head.wide = '0;
		head.n    = '0;
		head.q    = in_poly;
		head.side = in_side;
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		localparam bit     SERIES = (i < NT);
		localparam int     SUB    = SERIES ? (i % 4) : ((i - NT) % 2);
		localparam int     K      = SERIES ? (i / 4 + 1) : 1;
		localparam int     HK     = K / 2;
		localparam bit     ODD    = (K % 2) == 1;
		localparam int     SK     = QF + $clog2(K + 1);
		localparam longint MK     = (longint'(1) << SK) / K;

		estg_t src;
		estg_t nxt;
		logic  src_v;

		if (i == 0) begin : g_first
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stg_s[i-1];
			assign src_v = vld_s[i-1];
		end

		if (SERIES && SUB == 0) begin : g_tmul
			always_comb begin
				nxt      = src;
				nxt.wide = src.term * src.side.y;
			end
		end else if (SERIES && SUB == 1) begin : g_tround
			always_comb begin
				logic [WD_W-1:0] rw;
				nxt   = src;
				rw    = src.wide + WD_W'(QHALF);
				nxt.n = rw[QF +: TM_W] + TM_W'(HK);
			end
		end else if (SERIES && SUB == 2) begin : g_recip
			always_comb begin
				nxt      = src;
				nxt.wide = src.n * MK_W'(MK);
			end
		end else if (SERIES) begin : g_fix
			// reciprocal estimate is low by at most one
			always_comb begin
				logic [WD_W-1:0] sh;
				logic [TM_W-1:0] q0;
				logic [RM_W-1:0] qk;
				logic [RM_W-1:0] rem;
				logic [TM_W-1:0] tq;
				nxt = src;
				sh  = src.wide >> SK;
				q0  = sh[TM_W-1:0];
				qk  = RM_W'(q0) * RM_W'(K);
				rem = RM_W'(src.n) - qk;
				tq  = q0 + TM_W'(rem >= RM_W'(K));
				nxt.term = tq;
				if (ODD) begin
					nxt.sum = src.sum - SUM_W'(tq);
				end else begin
					nxt.sum = src.sum + SUM_W'(tq);
				end
			end
		end else if (SUB == 0) begin : g_smul
			always_comb begin
				nxt      = src;
				nxt.wide = src.sum * src.sum;
			end
		end else begin : g_sround
			always_comb begin
				logic [WD_W-1:0] rw;
				nxt     = src;
				rw      = src.wide + WD_W'(QHALF);
				nxt.sum = rw[QF +: SUM_W];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign expo      = stg_s[NST-1].sum;
	assign out_poly  = stg_s[NST-1].q;
	assign out_side  = stg_s[NST-1].side;

	a_exp_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] |-> stg_s[NST-1].sum <= SUM_W'(QONE))
		else $error("exponential above one");

endmodule

`default_nettype wire

// ===== design/erf_approximation.sv =====
// ----------------------------------------------------------------------------
// Error function unit
// Takes a Q4.12 argument and a mode bit per word and returns erf(x) (mode 0)
// or erfc(x) (mode 1) as Q2.14, using the five-coefficient rational fit
// erf = 1 - (a1 t + ... + a5 t^5) exp(-x^2), t = 1/(1 + p|x|), sign restored.
// An erfc of exactly two saturates to the largest positive code.
// Input channel: in_valid/in_stall with x_value, mode. Output channel:
// out_valid/out_stall with result_value. A word moves on a clock edge with
// valid high and stall low.
// The pipeline has 3 front stages, 31 divider stages (one quotient bit
// each), 10 polynomial stages, 60 exponential stages, 3 combine stages and
// the output register. One word is accepted per cycle while in_stall is low.
// When out_stall holds a result, the pipeline keeps moving until its last
// stage is occupied; then in_stall rises and everything holds, nothing lost.
// Reset clears all valid bits, the output's included; no state survives an item.
// ----------------------------------------------------------------------------
`default_nettype none

module erf_approximation (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [erfa_pkg::X_W-1:0]   x_value,
	input  wire logic                              mode,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [erfa_pkg::R_W-1:0]        result_value
);
	import erfa_pkg::*;

	localparam int PR_W = QM_W + SUM_W;

	logic en;
	logic out_free;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [A_W-1:0]     a_s1;
	logic               neg_s1, mode_s1;
	logic [PA_W-1:0]    pa_s2;
	logic [SQ_W-1:0]    sq_s2;
	logic               neg_s2, mode_s2;
	logic [D_W-1:0]     d_s3;
	side_t              side_s3;

	logic               div_v, horn_v, exp_v;
	logic [T_W-1:0]     div_t;
	side_t              div_side, horn_side, exp_side;
	logic signed [Q_W-1:0] horn_q, exp_q;
	logic [SUM_W-1:0]   exp_sum;

	logic [PR_W-1:0]        prod_s4;
	logic                   gneg_s4, neg_s4, mode_s4;
	logic signed [ER_W-1:0] erf_s5;
	logic                   neg_s5, mode_s5;
	logic signed [ER_W-1:0] r_s6;

	logic                   out_valid_q;
	logic signed [R_W-1:0]  result_q;

	logic [D_W-1:0]  d_nx;
	side_t           side_nx;
	logic [PR_W-1:0] prod_nx;
	logic signed [ER_W-1:0] erf_nx;
	logic signed [ER_W-1:0] r_nx;
	logic [R_W-1:0]  res_nx;

	assign out_free = !out_valid_q || !out_stall;
	assign en       = out_free || !v_s6;
	assign in_stall = !en;

	// front: magnitude, products, denominator and exponent argument
	always_comb begin
		logic [PA_W-1:0] pr;
		logic [S_W-1:0]  s;
		logic [S_W-1:0]  ys;
		pr   = pa_s2 + PA_W'(longint'(1) << (IN_FRAC_BITS - 1));
		d_nx = D_W'(QONE) + D_W'(pr >> IN_FRAC_BITS);
		s    = ((S_W'(sq_s2) + S_W'(SSHR_RND)) >> SSHR) << SSHL;
		ys   = s + S_W'(Y_RND);
		side_nx.neg  = neg_s2;
		side_nx.mode = mode_s2;
		side_nx.ez   = s >= S_W'(EXP_LIM);
		side_nx.y    = ys[YSH +: Y_W];
	end

	// back: scale by exponential, fold sign and mode
	always_comb begin
		logic [Q_W-1:0]         qabs;
		logic [SUM_W-1:0]       e;
		logic [PR_W-1:0]        rw;
		logic signed [ER_W-1:0] g;
		logic signed [ER_W-1:0] ev;
		qabs    = exp_q[Q_W-1] ? Q_W'(-exp_q) : Q_W'(exp_q);
		e       = exp_side.ez ? '0 : exp_sum;
		prod_nx = qabs[QM_W-1:0] * e;
		rw      = prod_s4 + PR_W'(QHALF);
		g       = ER_W'(rw[QF +: QM_W]);
		if (gneg_s4) begin
			g = -g;
		end
		erf_nx = ER_W'(QONE) - g;
		ev     = neg_s5 ? -erf_s5 : erf_s5;
		r_nx   = mode_s5 ? (ER_W'(QONE) - ev) : ev;
	end

	always_comb begin
		logic [ER_W-1:0] mag;
		logic [ER_W-1:0] rm;
		logic [ER_W-1:0] sat;
		logic            rneg;
		rneg = r_s6[ER_W-1];
		mag  = rneg ? ER_W'(-r_s6) : ER_W'(r_s6);
		rm   = (mag + ER_W'(O_RND)) >> OSH;
		if (rneg) begin
			sat    = (rm > ER_W'(longint'(1) << (R_W - 1))) ?
				ER_W'(longint'(1) << (R_W - 1)) : rm;
			res_nx = R_W'(ER_W'(0) - sat);
		end else begin
			sat    = (rm > ER_W'((longint'(1) << (R_W - 1)) - 1)) ?
				ER_W'((longint'(1) << (R_W - 1)) - 1) : rm;
			res_nx = R_W'(sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= exp_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= x_value[X_W-1];
			mode_s1 <= mode;
			a_s1    <= x_value[X_W-1] ? A_W'(-x_value) : A_W'(x_value);
			pa_s2   <= a_s1 * P_W'(COEF_P);
			sq_s2   <= a_s1 * a_s1;
			neg_s2  <= neg_s1;
			mode_s2 <= mode_s1;
			d_s3    <= d_nx;
			side_s3 <= side_nx;
			prod_s4 <= prod_nx;
			gneg_s4 <= exp_q[Q_W-1];
			neg_s4  <= exp_side.neg;
			mode_s4 <= exp_side.mode;
			erf_s5  <= erf_nx;
			neg_s5  <= neg_s4;
			mode_s5 <= mode_s4;
			r_s6    <= r_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			result_q <= res_nx;
		end
	end

	erfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.den      (d_s3),
		.in_side  (side_s3),
		.out_valid(div_v),
		.quot     (div_t),
		.out_side (div_side)
	);

	erfa_horner u_horner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_v),
		.t        (div_t),
		.in_side  (div_side),
		.out_valid(horn_v),
		.poly     (horn_q),
		.out_side (horn_side)
	);

	erfa_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (horn_v),
		.in_poly  (horn_q),
		.in_side  (horn_side),
		.out_valid(exp_v),
		.expo     (exp_sum),
		.out_poly (exp_q),
		.out_side (exp_side)
	);

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && v_s6 |=> v_s6 && $stable(r_s6))
		else $error("last stage moved while output blocked");

endmodule

`default_nettype wire
